// ===== sv/kkupw_pkg.sv =====
// Shared types and constants for the upwind advection stencil pipeline.
`timescale 1ns / 1ps
package kkupw_pkg;

	localparam int NSTG = 13;

	// 2^32 = 3 * K3 + 1
	localparam logic [30:0] K3 = 31'd1431655765;
	// ceil(2^34 / 3), exact quotient for any 33-bit dividend
	localparam logic [32:0] RECIP3 = 33'd5726623062;

	localparam logic signed [31:0] FIX_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] FIX_MIN = 32'sh8000_0000;

	typedef logic [NSTG:1] stage_en_t;

	typedef struct packed {
		stage_en_t en;
		stage_en_t vld;
	} pipe_ctl_t;

	typedef enum logic [0:0] {
		REG_INV_DX = 1'b0,
		REG_INV_DY = 1'b1
	} reg_idx_t;

endpackage

// ===== sv/kkupw_ctrl.sv =====
// Valid tracking and per-stage load enables for the stencil pipeline.
`timescale 1ns / 1ps
module kkupw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  out_ready,
	output logic                  in_ready,
	output logic                  out_valid,
	output kkupw_pkg::pipe_ctl_t  ctl
);

	kkupw_pkg::stage_en_t vld_q;
	kkupw_pkg::stage_en_t en;

	// a stage loads when out_ready is high or when it or any stage downstream has a hole
	genvar g;
	for (g = 1; g <= kkupw_pkg::NSTG; g++) begin : g_en
		assign en[g] = out_ready | ~(&vld_q[kkupw_pkg::NSTG:g]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= kkupw_pkg::NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[kkupw_pkg::NSTG];
	assign ctl.en    = en;
	assign ctl.vld   = vld_q;

endmodule

// ===== sv/kkupw_axis.sv =====
// One axis of the stencil: differences, velocity products, /12, spacing scale, clip.
`timescale 1ns / 1ps
module kkupw_axis #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  kkupw_pkg::stage_en_t  en,
	input  logic signed [31:0]    c,
	input  logic signed [31:0]    p1,
	input  logic signed [31:0]    p2,
	input  logic signed [31:0]    m1,
	input  logic signed [31:0]    m2,
	input  logic signed [31:0]    v,
	input  logic [31:0]           inv,
	output logic signed [31:0]    d_s12,
	output logic                  ovf_s12
);

	localparam int AW   = 37;
	localparam int AMW  = 36;
	localparam int BMW  = 36;
	localparam int B3W  = 37;
	localparam int AHW  = AMW - 32;
	localparam int BHW  = B3W - 32;
	localparam int PFW  = 70;
	localparam int RW   = 68 - FRAC_BITS;
	localparam int SW   = RW + 2;
	localparam int XW   = 69 - FRAC_BITS;
	localparam int TW   = XW - 2;
	localparam int HW   = TW - 32;
	localparam int HKW  = HW + 31;
	localparam int CMW  = 65 - FRAC_BITS;
	localparam int CHW  = CMW - 32;
	localparam int PCHW = CHW + 32;
	localparam int DW   = CMW + 33;
	localparam int MW   = DW - FRAC_BITS;

	localparam logic [PFW-1:0] HALF_P = PFW'(1) << (FRAC_BITS - 1);
	localparam logic [DW-1:0]  HALF_D = DW'(1) << (FRAC_BITS - 1);

	// s1: central and fourth differences
	logic signed [AW-1:0] a_c, bs_c;
	logic signed [AW-1:0] a_s1, bs_s1;
	logic signed [31:0]   v_s1;

	always_comb begin
		a_c  = (AW'(m2) - AW'(p2)) + ((AW'(p1) - AW'(m1)) <<< 3);
		bs_c = AW'(p2) + AW'(m2) - ((AW'(p1) + AW'(m1)) <<< 2)
			+ (AW'(c) <<< 2) + (AW'(c) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s1  <= a_c;
			bs_s1 <= bs_c;
			v_s1  <= v;
		end
	end

	// s2: magnitudes and product signs
	logic signed [AW-1:0] a_abs, bs_abs;
	logic [31:0]          v_abs;
	logic [AMW-1:0]       am_s2;
	logic [BMW-1:0]       bm_s2;
	logic [31:0]          vm_s2;
	logic                 pn_s2, qn_s2;

	always_comb begin
		a_abs  = a_s1[AW-1] ? -a_s1 : a_s1;
		bs_abs = bs_s1[AW-1] ? -bs_s1 : bs_s1;
		v_abs  = $unsigned(v_s1[31] ? -v_s1 : v_s1);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			am_s2 <= a_abs[AMW-1:0];
			bm_s2 <= bs_abs[BMW-1:0];
			vm_s2 <= v_abs;
			pn_s2 <= a_s1[AW-1] ^ v_s1[31];
			qn_s2 <= bs_s1[AW-1];
		end
	end

	// s3: 3 * |B|
	logic [AMW-1:0] am_s3;
	logic [B3W-1:0] b3_s3;
	logic [31:0]    vm_s3;
	logic           pn_s3, qn_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			am_s3 <= am_s2;
			b3_s3 <= B3W'(bm_s2) + (B3W'(bm_s2) << 1);
			vm_s3 <= vm_s2;
			pn_s3 <= pn_s2;
			qn_s3 <= qn_s2;
		end
	end

	// s4: velocity partial products
	logic [63:0]       pal_s4, pbl_s4;
	logic [AHW+31:0]   pah_s4;
	logic [BHW+31:0]   pbh_s4;
	logic              pn_s4, qn_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pal_s4 <= 64'(am_s3[31:0]) * 64'(vm_s3);
			pah_s4 <= (AHW+32)'(am_s3[AMW-1:32]) * (AHW+32)'(vm_s3);
			pbl_s4 <= 64'(b3_s3[31:0]) * 64'(vm_s3);
			pbh_s4 <= (BHW+32)'(b3_s3[B3W-1:32]) * (BHW+32)'(vm_s3);
			pn_s4  <= pn_s3;
			qn_s4  <= qn_s3;
		end
	end

	// s5: combine and round to FRAC_BITS
	logic [PFW-1:0] pf_c, qf_c;
	logic [RW-1:0]  p_s5, q_s5;
	logic           pn_s5, qn_s5;

	always_comb begin
		pf_c = PFW'({pah_s4, 32'd0}) + PFW'(pal_s4) + HALF_P;
		qf_c = PFW'({pbh_s4, 32'd0}) + PFW'(pbl_s4) + HALF_P;
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			p_s5  <= pf_c[FRAC_BITS +: RW];
			q_s5  <= qf_c[FRAC_BITS +: RW];
			pn_s5 <= pn_s4;
			qn_s5 <= qn_s4;
		end
	end

	// s6: signed sum
	logic signed [SW-1:0] ps_c, qs_c;
	logic signed [SW-1:0] s_s6;

	always_comb begin
		ps_c = $signed({2'b00, p_s5});
		qs_c = $signed({2'b00, q_s5});
		if (pn_s5) begin
			ps_c = -ps_c;
		end
		if (qn_s5) begin
			qs_c = -qs_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			s_s6 <= ps_c + qs_c;
		end
	end

	// s7: |s| + 6, then drop two bits (the /4 half of /12)
	logic signed [SW-1:0] x_c;
	logic [TW-1:0]        t_s7;
	logic                 sn_s7;

	always_comb begin
		x_c = s_s6[SW-1] ? (SW'(6) - s_s6) : (s_s6 + SW'(6));
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			t_s7  <= x_c[XW-1:2];
			sn_s7 <= s_s6[SW-1];
		end
	end

	// s8: t/3 = H*K3 + (H+L)/3 with t = H*2^32 + L
	logic [HKW-1:0] hk_s8;
	logic [32:0]    y_s8;
	logic           sn_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			hk_s8 <= HKW'(t_s7[TW-1:32]) * HKW'(kkupw_pkg::K3);
			y_s8  <= 33'(t_s7[TW-1:32]) + 33'(t_s7[31:0]);
			sn_s8 <= sn_s7;
		end
	end

	// s9: (H+L)/3 by reciprocal
	logic [65:0]    yp_c;
	logic [HKW-1:0] hk_s9;
	logic [31:0]    q2_s9;
	logic           sn_s9;

	always_comb begin
		yp_c = 66'(y_s8) * 66'(kkupw_pkg::RECIP3);
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			hk_s9 <= hk_s8;
			q2_s9 <= yp_c[65:34];
			sn_s9 <= sn_s8;
		end
	end

	// s10: quotient
	logic [HKW-1:0] cm_c;
	logic [CMW-1:0] cm_s10;
	logic           sn_s10;

	always_comb begin
		cm_c = hk_s9 + HKW'(q2_s9);
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			cm_s10 <= cm_c[CMW-1:0];
			sn_s10 <= sn_s9;
		end
	end

	// s11: spacing partial products
	logic [63:0]     pcl_s11;
	logic [PCHW-1:0] pch_s11;
	logic            sn_s11;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			pcl_s11 <= 64'(cm_s10[31:0]) * 64'(inv);
			pch_s11 <= PCHW'(cm_s10[CMW-1:32]) * PCHW'(inv);
			sn_s11  <= sn_s10;
		end
	end

	// s12: round, sign and clip to 32 bits
	logic [DW-1:0] prod_c;
	logic [MW-1:0] m_c;
	logic          ovf_c;
	logic signed [31:0] d_c;

	always_comb begin
		prod_c = DW'({pch_s11, 32'd0}) + DW'(pcl_s11) + HALF_D;
		m_c    = prod_c[DW-1:FRAC_BITS];
		if (sn_s11) begin
			ovf_c = (|m_c[MW-1:32]) | (m_c[31] & (|m_c[30:0]));
		end else begin
			ovf_c = |m_c[MW-1:31];
		end
		if (ovf_c) begin
			d_c = sn_s11 ? kkupw_pkg::FIX_MIN : kkupw_pkg::FIX_MAX;
		end else begin
			d_c = sn_s11 ? -$signed(m_c[31:0]) : $signed(m_c[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[12]) begin
			d_s12   <= d_c;
			ovf_s12 <= ovf_c;
		end
	end

endmodule

// ===== sv/kk_upwind_advection_stencil.sv =====
// Top level: config registers, two axis pipelines, final sum with saturation.
`timescale 1ns / 1ps
// Third-order upwind advection term for one grid cell in signed fixed point
// with FRAC_BITS fraction bits. Each input beat carries a five-point cross per
// axis plus the cell velocity; each output beat carries the saturated term and
// a flag set when any axis term or the final sum was clipped. The block takes
// one beat per clock while in_ready is high. Each beat passes through the 13
// register stages of the datapath (two split multiplies per axis, a reciprocal
// divide by 12, the spacing scale and the final add) before out_valid rises for
// it. Holes in the pipeline close up while the output is stalled, so input is
// refused only when all 13 stages hold beats and out_ready is low. inv_dx and
// inv_dy reset to 1.0 and should be written only when no beat is in flight.
module kk_upwind_advection_stencil #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [0:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] phi_center,
	input  logic signed [31:0] phi_east_near,
	input  logic signed [31:0] phi_east_far,
	input  logic signed [31:0] phi_west_near,
	input  logic signed [31:0] phi_west_far,
	input  logic signed [31:0] phi_north_near,
	input  logic signed [31:0] phi_north_far,
	input  logic signed [31:0] phi_south_near,
	input  logic signed [31:0] phi_south_far,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] advection_term,
	output logic               saturated
);

	localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
	localparam int NS = kkupw_pkg::NSTG;

	logic [31:0] inv_dx_q, inv_dy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_dx_q <= ONE;
			inv_dy_q <= ONE;
		end else if (cfg_wen) begin
			case (kkupw_pkg::reg_idx_t'(cfg_idx))
				kkupw_pkg::REG_INV_DX: inv_dx_q <= cfg_wdata;
				kkupw_pkg::REG_INV_DY: inv_dy_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	kkupw_pkg::pipe_ctl_t ctl;

	kkupw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.ctl       (ctl)
	);

	logic signed [31:0] dx_s12, dy_s12;
	logic               ovf_x_s12, ovf_y_s12;

	kkupw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
		.clk     (clk),
		.en      (ctl.en),
		.c       (phi_center),
		.p1      (phi_east_near),
		.p2      (phi_east_far),
		.m1      (phi_west_near),
		.m2      (phi_west_far),
		.v       (vel_x),
		.inv     (inv_dx_q),
		.d_s12   (dx_s12),
		.ovf_s12 (ovf_x_s12)
	);

	kkupw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
		.clk     (clk),
		.en      (ctl.en),
		.c       (phi_center),
		.p1      (phi_north_near),
		.p2      (phi_north_far),
		.m1      (phi_south_near),
		.m2      (phi_south_far),
		.v       (vel_y),
		.inv     (inv_dy_q),
		.d_s12   (dy_s12),
		.ovf_s12 (ovf_y_s12)
	);

	// s13: axis sum with saturation
	logic signed [32:0] sum_c;
	logic signed [31:0] res_c;
	logic               clip_c;
	logic signed [31:0] res_s13;
	logic               sat_s13;

	always_comb begin
		sum_c  = 33'(dx_s12) + 33'(dy_s12);
		clip_c = sum_c[32] ^ sum_c[31];
		if (clip_c) begin
			res_c = sum_c[32] ? kkupw_pkg::FIX_MIN : kkupw_pkg::FIX_MAX;
		end else begin
			res_c = sum_c[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[NS]) begin
			res_s13 <= res_c;
			sat_s13 <= clip_c | ovf_x_s12 | ovf_y_s12;
		end
	end

	assign advection_term = res_s13;
	assign saturated      = sat_s13;

`ifndef ASSERT_OFF
	a_full_only_when_blocked: assert property (
		@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready)
	) else $error("input refused while pipeline has room");

	a_accept_enters_s1: assert property (
		@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ctl.vld[1]
	) else $error("accepted beat not captured in first stage");

	a_axis_ovf_flags: assert property (
		@(posedge clk) disable iff (!arst_n)
		(ctl.en[NS] && ctl.vld[NS-1] && (ovf_x_s12 || ovf_y_s12)) |=> saturated
	) else $error("axis clip not reported in saturation flag");
`endif

endmodule
